// ===== hw/rtl/stq_pkg.sv =====
// Shared types and constants for the slot-time timer queue.
`timescale 1ns / 1ps

package stq_pkg;

	localparam int ID_W      = 4;
	localparam int OFFSET_W  = 16;
	localparam int SLOT_W    = 5;
	localparam int NOW_MFN_W = 24;
	localparam int FRAME_W   = 4;

	localparam logic FUNC_SCHED = 1'b0;
	localparam logic FUNC_RUN   = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [ID_W-1:0]      timer_id;
		logic [OFFSET_W-1:0]  frame_offset;
		logic [SLOT_W-1:0]    target_slot;
		logic [NOW_MFN_W-1:0] now_mfn;
		logic [FRAME_W-1:0]   now_frame;
		logic [SLOT_W-1:0]    now_slot;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] expired_id;
		logic            last_expired;
	} result_t;

	typedef struct packed {
		logic capture;
		logic dl_go;
		logic key_dl;
		logic walk;
		logic fin;
	} ctrl_cmd_t;

	typedef struct packed {
		logic func;
		logic sched_ok;
		logic dl_done;
		logic walk_done;
	} dp_status_t;

endpackage

// ===== hw/rtl/slot_time_timer_queue_core.sv =====
// Top level of the slot-time timer queue: controller plus datapath.
`timescale 1ns / 1ps

//  channel   signals                     direction  transfer
//  item      start, busy, item           in         start high while busy low
//  result    result_valid, result        out        one-cycle strobe, no stall
//
//  A schedule transaction keeps busy high through the deadline pipeline, the
//  walk of the entry memory (one read port, one entry per cycle) and the
//  finish state. A run transaction skips the deadline pipeline.
//  A schedule with an out-of-range id, or for a new timer on a full queue, is
//  taken without raising busy. Results leave one per cycle, one entry behind
//  the walk; the last comes at the latest in the cycle that busy falls.
//  Reset empties the queue at once.

module slot_time_timer_queue_core #(
	parameter int NUM_TIMERS            = 16,
	parameter int MFN_BITS              = 24,
	parameter int FRAMES_PER_MULTIFRAME = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  stq_pkg::item_t   item,
	output logic             busy,
	output logic             result_valid,
	output stq_pkg::result_t result
);

	stq_pkg::ctrl_cmd_t  cmd;
	stq_pkg::dp_status_t st;

	stq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	stq_dp #(
		.NUM_TIMERS            (NUM_TIMERS),
		.MFN_BITS              (MFN_BITS),
		.FRAMES_PER_MULTIFRAME (FRAMES_PER_MULTIFRAME)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== hw/rtl/stq_dl.sv =====
// Deadline pipeline: relative frame offset to absolute (mfn, frame).
`timescale 1ns / 1ps

module stq_dl #(
	parameter int MFN_BITS              = 24,
	parameter int FRAMES_PER_MULTIFRAME = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     go,
	input  stq_pkg::item_t                           item,
	output logic                                     done,
	output logic [MFN_BITS-1:0]                      dl_mfn,
	output logic [$clog2(FRAMES_PER_MULTIFRAME)-1:0] dl_frame
);

	localparam int FRM_W = $clog2(FRAMES_PER_MULTIFRAME);
	localparam int FW    = ((stq_pkg::OFFSET_W > stq_pkg::FRAME_W) ?
		stq_pkg::OFFSET_W : stq_pkg::FRAME_W) + 1;
	localparam int SW    = ((MFN_BITS > stq_pkg::NOW_MFN_W) ?
		MFN_BITS : stq_pkg::NOW_MFN_W) + 1;
	localparam logic [FW-1:0] RECIP   = FW'((2 ** FW) / FRAMES_PER_MULTIFRAME);
	localparam logic [FW-1:0] DIVISOR = FW'(FRAMES_PER_MULTIFRAME);

	logic v_s1, v_s2, v_s3, v_s4;

	logic [stq_pkg::OFFSET_W-1:0]  off;
	logic [FW-1:0]                 f_s1, f_s2;
	logic [stq_pkg::NOW_MFN_W-1:0] mfn_s1, mfn_s2, mfn_s3;
	logic [2*FW-1:0]               prod_s2;
	logic [FW-1:0]                 q_est;
	logic [2*FW-1:0]               qd;
	logic [FW-1:0]                 q_s3, r_s3;
	logic                          corr;
	logic [FW-1:0]                 r_fix;
	logic [SW-1:0]                 sum;
	logic [MFN_BITS-1:0]           mfn_s4;
	logic [FRM_W-1:0]              frame_s4;

	// an offset of zero with the slot already passed means next frame
	assign off = (item.frame_offset == '0 && item.target_slot < item.now_slot) ?
		stq_pkg::OFFSET_W'(1) : item.frame_offset;

	// reciprocal estimate is low by at most one
	assign q_est = prod_s2[2*FW-1:FW];
	assign qd    = (2*FW)'(q_est) * (2*FW)'(DIVISOR);
	assign corr  = (r_s3 >= DIVISOR);
	assign r_fix = corr ? (r_s3 - DIVISOR) : r_s3;
	assign sum   = SW'(mfn_s3) + SW'(q_s3) + SW'(corr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		f_s1     <= FW'(off) + FW'(item.now_frame);
		mfn_s1   <= item.now_mfn;
		prod_s2  <= (2*FW)'(f_s1) * (2*FW)'(RECIP);
		f_s2     <= f_s1;
		mfn_s2   <= mfn_s1;
		q_s3     <= q_est;
		r_s3     <= f_s2 - qd[FW-1:0];
		mfn_s3   <= mfn_s2;
		mfn_s4   <= sum[MFN_BITS-1:0];
		frame_s4 <= r_fix[FRM_W-1:0];
	end

	assign done     = v_s4;
	assign dl_mfn   = mfn_s4;
	assign dl_frame = frame_s4;

endmodule

// ===== hw/rtl/stq_dp.sv =====
// Datapath: entry memory, walk pointers, compare, compaction and result register.
`timescale 1ns / 1ps

module stq_dp #(
	parameter int NUM_TIMERS            = 16,
	parameter int MFN_BITS              = 24,
	parameter int FRAMES_PER_MULTIFRAME = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stq_pkg::item_t      item,
	input  stq_pkg::ctrl_cmd_t  cmd,
	output stq_pkg::dp_status_t st,
	output logic                result_valid,
	output stq_pkg::result_t    result
);

	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int FRM_W = $clog2(FRAMES_PER_MULTIFRAME);
	localparam int CMW   = (MFN_BITS > stq_pkg::NOW_MFN_W) ? MFN_BITS : stq_pkg::NOW_MFN_W;
	localparam int CFW   = (FRM_W > stq_pkg::FRAME_W) ? FRM_W : stq_pkg::FRAME_W;

	typedef struct packed {
		logic [MFN_BITS-1:0]       mfn;
		logic [FRM_W-1:0]          frame;
		logic [stq_pkg::SLOT_W-1:0] slot;
		logic [stq_pkg::ID_W-1:0]   id;
	} ent_t;

	ent_t ent_mem_q [NUM_TIMERS];
	ent_t rd_data_q, new_ent_q, hold_q, hold_nxt, wr_data;

	logic [CNT_W-1:0]            count_q, rd_ptr_q, wr_ptr_q, wr_ptr_nxt;
	logic [NUM_TIMERS-1:0]       pending_q;
	logic                        proc_v_q, run_q;
	logic                        hold_v_q, ins_q, exp_q, pend_v_q;
	logic                        hold_v_nxt, ins_nxt, exp_nxt, pend_v_nxt;
	logic [stq_pkg::ID_W-1:0]    pend_id_q, pend_id_nxt;
	logic [CMW-1:0]              key_mfn_q;
	logic [CFW-1:0]              key_frame_q;
	logic [stq_pkg::SLOT_W-1:0]  key_slot_q;

	logic                        rd_en, proc, wr_en, emit, emit_last, clr_pend;
	logic                        id_ok, full;
	logic [MFN_BITS-1:0]         mfn_diff;
	logic                        mfn_after, mfn_eq, later_e, match_e;
	logic [CFW-1:0]              e_frm;
	logic                        dl_done;
	logic [MFN_BITS-1:0]         dl_mfn;
	logic [FRM_W-1:0]            dl_frame;
	stq_pkg::result_t            result_q;
	logic                        result_valid_q;

	stq_dl #(
		.MFN_BITS              (MFN_BITS),
		.FRAMES_PER_MULTIFRAME (FRAMES_PER_MULTIFRAME)
	) u_dl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.dl_go),
		.item     (item),
		.done     (dl_done),
		.dl_mfn   (dl_mfn),
		.dl_frame (dl_frame)
	);

	assign id_ok = (32'(item.timer_id) < NUM_TIMERS);
	assign full  = (count_q == CNT_W'(NUM_TIMERS));

	assign st.func      = item.func;
	assign st.sched_ok  = id_ok && (!full || pending_q[IDX_W'(item.timer_id)]);
	assign st.dl_done   = dl_done;
	// the last entry is processed in the cycle the read pointer reaches the count
	assign st.walk_done = (rd_ptr_q == count_q);

	assign rd_en = cmd.walk && (rd_ptr_q < count_q);
	assign proc  = cmd.walk && proc_v_q;

	// serial-number order on the multiframe, then frame, then slot
	assign mfn_diff  = rd_data_q.mfn - key_mfn_q[MFN_BITS-1:0];
	assign mfn_after = (mfn_diff != '0) && !mfn_diff[MFN_BITS-1];
	assign mfn_eq    = (CMW'(rd_data_q.mfn) == key_mfn_q);
	assign e_frm     = CFW'(rd_data_q.frame);
	assign later_e   = mfn_after || (mfn_eq && ((e_frm != key_frame_q) ?
		(e_frm > key_frame_q) : (rd_data_q.slot > key_slot_q)));
	assign match_e   = (rd_data_q.id == new_ent_q.id);

	// one entry in and at most one entry out per cycle; hold carries the
	// entry displaced by an insertion
	always_comb begin
		wr_en       = 1'b0;
		wr_data     = rd_data_q;
		hold_nxt    = hold_q;
		hold_v_nxt  = hold_v_q;
		ins_nxt     = ins_q;
		exp_nxt     = exp_q;
		pend_id_nxt = pend_id_q;
		pend_v_nxt  = pend_v_q;
		emit        = 1'b0;
		emit_last   = 1'b0;
		clr_pend    = 1'b0;
		if (proc) begin
			if (run_q) begin
				if (exp_q && !later_e) begin
					emit        = pend_v_q;
					pend_id_nxt = rd_data_q.id;
					pend_v_nxt  = 1'b1;
					clr_pend    = 1'b1;
				end else begin
					exp_nxt    = 1'b0;
					emit       = pend_v_q;
					emit_last  = 1'b1;
					pend_v_nxt = 1'b0;
					wr_en      = 1'b1;
				end
			end else if (match_e) begin
				// drop the old copy of the timer being rescheduled
				if (hold_v_q) begin
					wr_en      = 1'b1;
					wr_data    = hold_q;
					hold_v_nxt = 1'b0;
				end
			end else if (!ins_q && later_e) begin
				wr_en      = 1'b1;
				wr_data    = new_ent_q;
				hold_nxt   = rd_data_q;
				hold_v_nxt = 1'b1;
				ins_nxt    = 1'b1;
			end else if (hold_v_q) begin
				wr_en    = 1'b1;
				wr_data  = hold_q;
				hold_nxt = rd_data_q;
			end else begin
				wr_en = 1'b1;
			end
		end else if (cmd.fin) begin
			if (run_q) begin
				emit       = pend_v_q;
				emit_last  = 1'b1;
				pend_v_nxt = 1'b0;
			end else if (hold_v_q) begin
				wr_en      = 1'b1;
				wr_data    = hold_q;
				hold_v_nxt = 1'b0;
			end else if (!ins_q) begin
				wr_en   = 1'b1;
				wr_data = new_ent_q;
				ins_nxt = 1'b1;
			end
		end
	end

	assign wr_ptr_nxt = wr_ptr_q + CNT_W'(wr_en);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem_q[wr_ptr_q[IDX_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= ent_mem_q[rd_ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			pending_q      <= '0;
			rd_ptr_q       <= '0;
			wr_ptr_q       <= '0;
			proc_v_q       <= 1'b0;
			run_q          <= 1'b0;
			hold_v_q       <= 1'b0;
			ins_q          <= 1'b0;
			exp_q          <= 1'b0;
			pend_v_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
			if (cmd.capture) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				proc_v_q <= 1'b0;
				run_q    <= (item.func == stq_pkg::FUNC_RUN);
				hold_v_q <= 1'b0;
				ins_q    <= 1'b0;
				exp_q    <= 1'b1;
				pend_v_q <= 1'b0;
			end else begin
				proc_v_q <= rd_en;
				if (rd_en) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end
				wr_ptr_q <= wr_ptr_nxt;
				hold_v_q <= hold_v_nxt;
				ins_q    <= ins_nxt;
				exp_q    <= exp_nxt;
				pend_v_q <= pend_v_nxt;
				if (clr_pend) begin
					pending_q[IDX_W'(rd_data_q.id)] <= 1'b0;
				end
				if (cmd.fin) begin
					count_q <= wr_ptr_nxt;
					if (!run_q) begin
						pending_q[IDX_W'(new_ent_q.id)] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		hold_q    <= hold_nxt;
		pend_id_q <= pend_id_nxt;
		result_q  <= '{expired_id: pend_id_q, last_expired: emit_last};
		if (cmd.capture) begin
			new_ent_q.slot <= item.target_slot;
			new_ent_q.id   <= item.timer_id;
			key_mfn_q      <= CMW'(item.now_mfn);
			key_frame_q    <= CFW'(item.now_frame);
			key_slot_q     <= item.now_slot;
		end else if (cmd.key_dl) begin
			new_ent_q.mfn   <= dl_mfn;
			new_ent_q.frame <= dl_frame;
			key_mfn_q       <= CMW'(dl_mfn);
			key_frame_q     <= CFW'(dl_frame);
			key_slot_q      <= new_ent_q.slot;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/stq_ctrl.sv =====
// Controller state machine: sequences deadline, queue walk and finish.
`timescale 1ns / 1ps

module stq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  stq_pkg::dp_status_t st,
	output stq_pkg::ctrl_cmd_t  cmd,
	output logic                busy
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_WALK = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (st.func == stq_pkg::FUNC_RUN) begin
						state_nxt = ST_WALK;
					end else if (st.sched_ok) begin
						cmd.dl_go = 1'b1;
						state_nxt = ST_CALC;
					end
				end
			end
			ST_CALC: begin
				if (st.dl_done) begin
					cmd.key_dl = 1'b1;
					state_nxt  = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (st.walk_done) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin   = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
